FILE: rtl/q4bd_pkg.sv
// Package: payload types and helpers for the q4 block dequantizer.
`default_nettype none
package q4bd_pkg;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_INF   = 8'hFF;
	localparam logic [4:0]  HEXP_MAX  = 5'h1F;
	localparam logic [7:0]  EXP_BIAS  = 8'd102;
	localparam logic [3:0]  NIB_MID   = 4'd8;

	typedef struct packed {
		logic [15:0] scale_bits;
		logic [7:0]  quant_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] value_even;
		logic [31:0] value_odd;
	} out_item_t;

	// per-lane decoded factor and product
	typedef struct packed {
		logic       neg;
		logic [3:0] kmag;
	} factor_t;

	typedef struct packed {
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic        sign;
		logic [4:0]  hexp;
		logic [13:0] prod;
	} lane_t;
endpackage
`default_nettype wire

FILE: rtl/q4bd_lane.sv
// Lane: three-stage dequantization of one nibble against the half scale.
`default_nettype none
module q4bd_lane import q4bd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en_s1,
	input  wire logic        en_s2,
	input  wire logic        en_s3,
	input  wire logic [15:0] scale_bits,
	input  wire logic [3:0]  nibble,
	output logic [31:0]      value
);
	factor_t     fac_s1;
	logic [15:0] h_s1;
	lane_t       ln_s2;
	lane_t       ln_c;
	logic [31:0] val_c;
	logic [1:0]  shift_c;
	logic [7:0]  exp_c;
	logic [22:0] man_c;
	logic [22:0] pext_c;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			h_s1       <= scale_bits;
			fac_s1.neg <= nibble < NIB_MID;
			fac_s1.kmag <= (nibble < NIB_MID) ? NIB_MID - nibble : nibble - NIB_MID;
		end
	end

	always_comb begin
		ln_c.sign    = h_s1[15] ^ fac_s1.neg;
		ln_c.hexp    = h_s1[14:10];
		ln_c.is_nan  = (h_s1[14:10] == HEXP_MAX) &&
			((h_s1[9:0] != 10'd0) || (fac_s1.kmag == 4'd0));
		ln_c.is_inf  = (h_s1[14:10] == HEXP_MAX);
		ln_c.is_zero = (h_s1[14:10] == 5'd0) || (fac_s1.kmag == 4'd0);
		ln_c.prod    = {4'b0001, h_s1[9:0]} * {10'd0, fac_s1.kmag};
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ln_s2 <= ln_c;
		end
	end

	always_comb begin
		priority if (ln_s2.prod[13]) shift_c = 2'd3;
		else if (ln_s2.prod[12])     shift_c = 2'd2;
		else if (ln_s2.prod[11])     shift_c = 2'd1;
		else                         shift_c = 2'd0;
		exp_c  = {3'd0, ln_s2.hexp} + EXP_BIAS + 8'd10 + {6'd0, shift_c};
		pext_c = {9'd0, ln_s2.prod} << (5'd13 - {3'd0, shift_c});
		man_c  = pext_c;
		priority if (ln_s2.is_nan) val_c = QNAN_BITS;
		else if (ln_s2.is_inf)     val_c = {ln_s2.sign, EXP_INF, 23'd0};
		else if (ln_s2.is_zero)    val_c = {ln_s2.sign, 31'd0};
		else                       val_c = {ln_s2.sign, exp_c, man_c};
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			value <= val_c;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/q4_block_dequantizer_unit.sv
// Top level: q4 block dequantizer, three-stage pipeline with two lanes.
//  channel | signals                        | payload
//  in      | in_valid, in_ready, in_data    | in_item_t  (scale_bits, quant_byte)
//  out     | out_valid, out_ready, out_data | out_item_t (value_even, value_odd)
// One transaction enters per cycle while the output does not stall; it passes
// through the decode, multiply and pack stages. Reset clears the stage valid bits.
// A stage advances when it is empty or the stage after it advances, so a stall
// holds the last stage and each occupied stage in an unbroken run behind it.
`default_nettype none
module q4_block_dequantizer_unit import q4bd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	logic vld_s1, vld_s2, vld_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	q4bd_lane u_even (
		.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .en_s3(en_s3),
		.scale_bits(in_data.scale_bits), .nibble(in_data.quant_byte[3:0]),
		.value(out_data.value_even)
	);

	q4bd_lane u_odd (
		.clk(clk), .en_s1(en_s1), .en_s2(en_s2), .en_s3(en_s3),
		.scale_bits(in_data.scale_bits), .nibble(in_data.quant_byte[7:4]),
		.value(out_data.value_odd)
	);
endmodule
`default_nettype wire

FILE: verif/q4_block_dequantizer_checker.sv
// Checker: watches both channels of the q4 block dequantizer, predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none
module q4_block_dequantizer_checker import q4bd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_ready,
	input  wire in_item_t  in_data,
	input  wire logic      out_valid,
	input  wire logic      out_ready,
	input  wire out_item_t out_data,
	output int             fail_count,
	output int             pending_count
);
	out_item_t expected_q[$];

	function automatic logic [31:0] half_times_weight(logic [15:0] h, logic [3:0] nib);
		logic        hs;
		logic [4:0]  he;
		logic [9:0]  hm;
		logic        wneg;
		logic [3:0]  wmag;
		logic [31:0] sgn;
		logic [13:0] prod;
		int          msb;
		logic [7:0]  ex;
		logic [22:0] frac;
		hs = h[15];
		he = h[14:10];
		hm = h[9:0];
		wneg = nib < NIB_MID;
		wmag = wneg ? NIB_MID - nib : nib - NIB_MID;
		sgn = {hs ^ wneg, 31'd0};
		if (he == HEXP_MAX) begin
			if (hm != 0 || wmag == 0)
				return QNAN_BITS;
			return sgn | {1'b0, EXP_INF, 23'd0};
		end
		if (he == 0 || wmag == 0)
			return sgn;
		prod = {4'b0001, hm} * {10'd0, wmag};
		msb = 10;
		for (int b = 11; b <= 13; b++)
			if (prod[b])
				msb = b;
		ex = 8'(he) + EXP_BIAS + 8'(msb);
		frac = 23'({9'd0, prod} << (23 - msb));
		return sgn | {1'b0, ex, frac};
	endfunction

	assign pending_count = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back({half_times_weight(in_data.scale_bits, in_data.quant_byte[3:0]),
					half_times_weight(in_data.scale_bits, in_data.quant_byte[7:4])});
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected transaction %h", out_data);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (want.value_even !== out_data.value_even) begin
						$error("value_even expected %h actual %h", want.value_even,
							out_data.value_even);
						errs++;
					end
					if (want.value_odd !== out_data.value_odd) begin
						$error("value_odd expected %h actual %h", want.value_odd,
							out_data.value_odd);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule
`default_nettype wire

FILE: verif/q4_block_dequantizer_unit_tb.sv
// Testbench top: drives the q4 block dequantizer with directed and random transactions.
`timescale 1ns / 1ps
`default_nettype none
module q4_block_dequantizer_unit_tb;
	import q4bd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1250;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	int        fail_count;
	int        pending_count;
	int        idle_cycles;
	int        sent;
	bit        long_hold;
	bit        sending_done;

	q4_block_dequantizer_unit dut (.*);

	q4_block_dequantizer_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(16'h0400, 16'h7BFF)) | (16'($urandom_range(0, 1)) << 15);
		if (r < 80)
			return {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom_range(0, 1) ? 0 : $urandom)};
		if (r < 90)
			return {1'($urandom_range(0, 1)), 5'h00, 10'($urandom)};
		return 16'($urandom);
	endfunction

	task automatic send(logic [15:0] s, logic [7:0] q);
		in_valid <= 1'b1;
		in_data <= '{scale_bits: s, quant_byte: q};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic pause_send();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// receiver: random stalls plus one long hold-off
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (60) @(negedge clk);
				long_hold = 0;
			end
			g = gap_len();
			if (sent > 400 && sent < 600)
				g = 0;
			out_ready <= (g == 0);
			repeat (g) @(negedge clk);
			out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] dir_scales[8];
		int tail;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		sent = 0;
		long_hold = 0;
		sending_done = 0;
		dir_scales = '{16'h3C00, 16'hFBFF, 16'h0001, 16'h8000, 16'h7C00, 16'hFC00,
			16'h7E01, 16'h0400};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_scales[i])
			send(dir_scales[i], 8'(i * 8'h35 + 8'h08));
		send(16'h7BFF, 8'h0F);
		send(16'hFFFF, 8'hF0);
		send(16'h5555, 8'hAA);
		send(16'h2AAA, 8'h55);
		send(16'h0000, 8'h00);
		send(16'h7C00, 8'h88);
		long_hold = 1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send(pick_scale(), 8'($urandom));
			if (i == 600) begin
				in_valid <= 1'b0;
				while (pending_count != 0) @(negedge clk);
			end else if (!long_hold && !(i > 400 && i < 600))
				pause_send();
		end
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		tail = 0;
		while (tail < 10) begin
			@(negedge clk);
			tail++;
		end
		$display("Covered %0d transactions: half scales of every class, all nibble pairs,", sent);
		$display("with random stalls on both sides and a long output hold-off.");
		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
